@@ rtl/core/mted_pkg.sv @@
// shared types and constants for the multi-tap echo core
`default_nettype none
package mted_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int TAP_SPACING = 5000;
  localparam int NUM_TAPS    = 9;
  localparam int ACC_W       = SAMPLE_W + 2;
  localparam int PTR_W       = $clog2(TAP_SPACING);
  localparam int SHIFT_W     = $clog2(NUM_TAPS + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic [PTR_W-1:0]           ptr_t;
  typedef logic [SHIFT_W-1:0]         shift_t;

  localparam ptr_t PTR_LAST = PTR_W'(TAP_SPACING - 1);
  localparam acc_t SAT_HI   = acc_t'((2 ** (SAMPLE_W - 1)) - 1);
  localparam acc_t SAT_LO   = acc_t'(-(2 ** (SAMPLE_W - 1)));

  // one step of an item travelling down the row of cells
  typedef struct packed {
    logic    valid;
    sample_t sample;
    acc_t    acc;
  } link_t;

endpackage
`default_nettype wire

@@ rtl/core/mted_cell.sv @@
// one delay cell: a tap-spacing deep delay segment plus its weighted tap add
`default_nettype none
module mted_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire mted_pkg::shift_t shift,
  input  wire mted_pkg::link_t  link_in,
  output mted_pkg::link_t       link_out
);
  import mted_pkg::*;

  sample_t mem [TAP_SPACING];
  ptr_t    ptr;
  logic    full;
  logic    hold_valid;
  logic    rd_full;
  sample_t rd_data;
  acc_t    acc_hold;
  sample_t tap;
  acc_t    tap_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr        <= '0;
      full       <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= link_in.valid;
      if (link_in.valid) begin
        if (ptr == PTR_LAST) begin
          ptr  <= '0;
          full <= 1'b1;
        end else begin
          ptr <= ptr + PTR_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_full  <= full;
    acc_hold <= link_in.acc;
  end

  // read-first delay memory
  always_ff @(posedge clk) begin
    if (link_in.valid) begin
      rd_data  <= mem[ptr];
      mem[ptr] <= link_in.sample;
    end
  end

  // unwritten slots read as silence
  assign tap     = rd_full ? rd_data : '0;
  assign tap_ext = {{(ACC_W - SAMPLE_W){tap[SAMPLE_W-1]}}, tap};

  assign link_out.valid  = hold_valid;
  assign link_out.sample = tap;
  assign link_out.acc    = acc_hold + (tap_ext >>> shift);

endmodule
`default_nettype wire

@@ rtl/core/multi_tap_echo_delay_core.sv @@
// top level of the multi-tap echo core: control, cell row, saturation and output register
`default_nettype none
// Takes one signed Q1.23 sample per item and returns one sample. With echo_enable set,
// the item walks a row of nine delay cells, one cell per cycle, each cell delaying by
// 5000 items and adding its tap scaled by 0.5^k; the sum is saturated to 24 bits. An
// echoed item leaves the nine cells for the holding register, while a passed-through
// item (echo_enable clear) goes straight into it. The next item is accepted only once
// the held item moves into the output register, so a stalled output holds it back. Each
// cell keeps a fill flag so history not yet written reads as zero, so no clearing pass
// runs after reset. Write echo_enable only while no item is in flight.
module multi_tap_echo_delay_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              write_enable,
  input  wire logic              write_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire mted_pkg::sample_t sample_in,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mted_pkg::sample_t      sample_out
);
  import mted_pkg::*;

  link_t   links [NUM_TAPS+1];
  logic    echo_enable;
  logic    busy;
  logic    pend_valid;
  sample_t pend_sample;
  logic    accept;
  logic    move;
  acc_t    acc_end;
  sample_t sat_sample;

  assign in_stall = busy | pend_valid;
  assign accept   = in_valid & ~in_stall;
  assign move     = pend_valid & (~out_valid | ~out_stall);

  assign links[0].valid  = accept & echo_enable;
  assign links[0].sample = sample_in;
  assign links[0].acc    = {{(ACC_W - SAMPLE_W){sample_in[SAMPLE_W-1]}}, sample_in};

  for (genvar g = 0; g < NUM_TAPS; g++) begin : g_cell
    mted_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (SHIFT_W'(g + 1)),
      .link_in  (links[g]),
      .link_out (links[g+1])
    );
  end

  assign acc_end = links[NUM_TAPS].acc;

  always_comb begin
    if (acc_end > SAT_HI) begin
      sat_sample = SAT_HI[SAMPLE_W-1:0];
    end else if (acc_end < SAT_LO) begin
      sat_sample = SAT_LO[SAMPLE_W-1:0];
    end else begin
      sat_sample = acc_end[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_enable <= 1'b1;
      busy        <= 1'b0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (write_enable) begin
        echo_enable <= write_data;
      end
      if (accept && echo_enable) begin
        busy <= 1'b1;
      end else if (links[NUM_TAPS].valid) begin
        busy <= 1'b0;
      end
      if ((accept && !echo_enable) || links[NUM_TAPS].valid) begin
        pend_valid <= 1'b1;
      end else if (move) begin
        pend_valid <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !echo_enable) begin
      pend_sample <= sample_in;
    end else if (links[NUM_TAPS].valid) begin
      pend_sample <= sat_sample;
    end
    if (move) begin
      sample_out <= pend_sample;
    end
  end

endmodule
`default_nettype wire

@@ verif/multi_tap_echo_delay_core_test.sv @@
// self-checking testbench for the multi-tap echo core: directed rows, random echo runs
module multi_tap_echo_delay_core_test;
  import mted_pkg::*;

  localparam int HIST_DEPTH = 65536;
  localparam int ECHO_RUN   = 330;
  localparam int HOLD_LEN   = 400;
  localparam int TAIL       = 40;
  localparam logic signed [31:0] SAMPLE_PEAK  = (2 ** (SAMPLE_W - 1)) - 1;
  localparam logic signed [31:0] SAMPLE_FLOOR = -(2 ** (SAMPLE_W - 1));

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    sample_t   value;
    logic      typed;
    sample_t   want;
  } row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    write_enable = 1'b0;
  logic    write_data = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  sample_t sample_in = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  sample_t sample_out;

  // predictor state
  sample_t     ring [HIST_DEPTH];
  logic [15:0] ring_wr;
  logic        echo_on;

  sample_t echo_due [$];
  sample_t due_now;
  int      mismatches = 0;
  int      results_seen = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  logic    hold_armed = 1'b0;
  logic    hold_spent = 1'b0;
  int      hold_left = 0;

  // early rows see only reset zeros in the taps, so the echo equals the input
  row_t script [18] = '{
    '{ROW_ITEM, 24'sh000000, 1'b1, 24'sh000000},
    '{ROW_ITEM, 24'sh7FFFFF, 1'b1, 24'sh7FFFFF},
    '{ROW_ITEM, 24'sh800000, 1'b1, 24'sh800000},
    '{ROW_ITEM, 24'shFFFFFF, 1'b1, 24'shFFFFFF},
    '{ROW_ITEM, 24'sh000001, 1'b1, 24'sh000001},
    '{ROW_ITEM, 24'sh555555, 1'b1, 24'sh555555},
    '{ROW_ITEM, 24'shAAAAAA, 1'b1, 24'shAAAAAA},
    '{ROW_CFG,  24'sh000000, 1'b0, 24'sh000000},
    '{ROW_ITEM, 24'sh01E240, 1'b1, 24'sh01E240},
    '{ROW_ITEM, 24'sh800000, 1'b1, 24'sh800000},
    '{ROW_ITEM, 24'sh7FFFFF, 1'b1, 24'sh7FFFFF},
    '{ROW_ITEM, 24'shFFFFFB, 1'b1, 24'shFFFFFB},
    '{ROW_CFG,  24'sh000001, 1'b0, 24'sh000000},
    '{ROW_ITEM, 24'shFFFFF9, 1'b1, 24'shFFFFF9},
    '{ROW_ITEM, 24'sh7FFFFE, 1'b0, 24'sh000000},
    '{ROW_ITEM, 24'sh800001, 1'b0, 24'sh000000},
    '{ROW_ITEM, 24'sh123456, 1'b0, 24'sh000000},
    '{ROW_ITEM, 24'shEDCBA9, 1'b0, 24'sh000000}
  };

  multi_tap_echo_delay_core dut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_data   (write_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_in    (sample_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_out   (sample_out)
  );

  always #2 clk = ~clk;

  function automatic sample_t echo_of(input sample_t x);
    logic signed [31:0] acc;
    sample_t            tap;
    logic [15:0]        pos;
    acc = x;
    if (echo_on) begin
      ring[ring_wr] = x;
      for (int k = 1; k <= NUM_TAPS; k++) begin
        pos = ring_wr - 16'(k * TAP_SPACING);
        tap = ring[pos] >>> k;
        acc = acc + tap;
      end
      ring_wr = ring_wr + 16'd1;
      if (acc > SAMPLE_PEAK) acc = SAMPLE_PEAK;
      if (acc < SAMPLE_FLOOR) acc = SAMPLE_FLOOR;
    end
    return sample_t'(acc);
  endfunction

  function automatic sample_t pick_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) return sample_t'($urandom);
    if (pick < 70) begin
      case ($urandom_range(3))
        0: return sample_t'(SAMPLE_PEAK);
        1: return sample_t'(SAMPLE_FLOOR);
        2: return '0;
        default: return '1;
      endcase
    end
    if (pick < 90) return sample_t'(int'($urandom_range(4095)) - 2048);
    return sample_t'(-2 * int'($urandom_range(200)) - 1);
  endfunction

  task automatic flag_mismatch(input string what, input sample_t got, input sample_t want);
    mismatches++;
    $display("tb: mismatch on result %0d: %s, got %0d, want %0d",
             results_seen, what, got, want);
  endtask

  task automatic offer(input sample_t x, input logic typed, input sample_t want);
    sample_t due;
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid  <= 1'b1;
    sample_in <= x;
    do @(posedge clk); while (in_stall);
    due = echo_of(x);
    if (typed) due = want;
    echo_due = {echo_due, due};
  endtask

  task automatic set_echo(input logic on);
    @(negedge clk);
    in_valid <= 1'b0;
    while (echo_due.size() != 0) @(posedge clk);
    @(negedge clk);
    write_enable <= 1'b1;
    write_data   <= on;
    echo_on = on;
    @(negedge clk);
    write_enable <= 1'b0;
  endtask

  // receiver: random stalls, plus one long hold-off so the core backs up
  always @(negedge clk) begin
    if (hold_armed && !hold_spent) begin
      hold_left  = HOLD_LEN;
      hold_spent = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (echo_due.size() == 0) begin
        flag_mismatch("item with nothing due", sample_out, '0);
      end else begin
        due_now = echo_due.pop_front();
        if (sample_out !== due_now) flag_mismatch("sample_out", sample_out, due_now);
      end
    end
  end

  initial begin
    #48_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int   echoed;
    int   len;
    logic on;
    foreach (ring[i]) ring[i] = '0;
    ring_wr = '0;
    echo_on = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) set_echo(script[i].value[0]);
      else offer(script[i].value, script[i].typed, script[i].want);
    end

    // echo runs with echo_enable toggled now and then
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 45 : 0;
      recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 27 : 0;
      echoed = 0;
      while (echoed < ECHO_RUN) begin
        on  = ($urandom_range(7) != 0);
        len = on ? $urandom_range(40, 120) : $urandom_range(4, 16);
        set_echo(on);
        if (phase == 2) hold_armed = 1'b1;
        repeat (len) offer(pick_sample(), 1'b0, '0);
        if (on) echoed += len;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (echo_due.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
